### src/e2c_pkg.sv
`timescale 1ns / 1ps
// e2c_pkg: shared widths, constants, result structs and the month table
// for the epoch to calendar pipeline. no dependencies.
package e2c_pkg;

  localparam int EPOCH_BITS_DEF = 32;
  localparam int NSTAGE         = 13;

  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int SECOND_W  = 6;
  localparam int WEEKDAY_W = 3;

  // seconds of day split as {sod / 128 remainder mod 675, low 7 bits}
  localparam int SOD_W     = 17;
  localparam int DAY_SHIFT = 7;
  localparam int DAY_HI    = 675;

  localparam int DOE_W = 18;
  localparam int DOY_W = 9;
  localparam int YOE_W = 9;
  localparam int MP_W  = 4;

  // shifted month index of january, and the month code of february
  localparam logic [MP_W-1:0]    MP_JAN    = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [WEEKDAY_W-1:0] weekday;
  } date_t;

  // first day of each month counted from march 1
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### src/e2c_split.sv
`timescale 1ns / 1ps
// e2c_split: stages 0 and 1, epoch seconds into whole days and seconds of day.
// depends on e2c_pkg.
module e2c_split #(
  parameter int EPOCH_BITS = e2c_pkg::EPOCH_BITS_DEF
) (
  input  logic                        clk,
  input  e2c_pkg::stage_en_t          adv,
  input  logic [EPOCH_BITS-1:0]       epoch_seconds,
  output logic [EPOCH_BITS-17:0]      days,
  output logic [e2c_pkg::SOD_W-1:0]   sod
);
  import e2c_pkg::*;

  localparam int XW = EPOCH_BITS - DAY_SHIFT;
  localparam int SD = XW + 10;
  localparam int PW = 2 * XW + 1;
  localparam int DW = EPOCH_BITS - 16;
  localparam logic [XW:0] M_DAY =
    (XW+1)'(((64'd1 << SD) + 64'(DAY_HI - 1)) / 64'(DAY_HI));

  logic [EPOCH_BITS-1:0] t0;
  logic [PW-1:0]         prod0;
  logic [DW-1:0]         days_c;
  logic [XW-1:0]         rem_c;

  assign days_c = prod0[PW-1:SD];
  assign rem_c  = t0[EPOCH_BITS-1:DAY_SHIFT] - XW'(days_c) * XW'(DAY_HI);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t0    <= epoch_seconds;
      prod0 <= PW'(epoch_seconds[EPOCH_BITS-1:DAY_SHIFT]) * PW'(M_DAY);
    end
    if (adv[1]) begin
      days <= days_c;
      sod  <= {rem_c[SOD_W-DAY_SHIFT-1:0], t0[DAY_SHIFT-1:0]};
    end
  end

endmodule

### src/e2c_tod.sv
`timescale 1ns / 1ps
// e2c_tod: stages 2 to 12, seconds of day into hour, minute and second,
// then a delay line to line up with the date path. depends on e2c_pkg.
module e2c_tod (
  input  logic                      clk,
  input  e2c_pkg::stage_en_t        adv,
  input  logic [e2c_pkg::SOD_W-1:0] sod,
  output e2c_pkg::tod_t             tod
);
  import e2c_pkg::*;

  localparam int HOUR_SECS = 3600;
  localparam int MIN_SECS  = 60;
  localparam logic [17:0] M_HOUR =
    18'(((64'd1 << 29) + 64'(HOUR_SECS - 1)) / 64'(HOUR_SECS));
  localparam logic [12:0] M_MIN =
    13'(((64'd1 << 18) + 64'(MIN_SECS - 1)) / 64'(MIN_SECS));

  logic [SOD_W-1:0]  sod2;
  logic [34:0]       hp2;
  logic [HOUR_W-1:0] hour3, hour4;
  logic [11:0]       rem3, rem4;
  logic [24:0]       mp4;
  logic [SOD_W-1:0]  rem_c;
  logic [11:0]       sec_c;
  tod_t              tod_line [5:NSTAGE-1];

  assign rem_c = sod2 - SOD_W'(hp2[33:29]) * SOD_W'(HOUR_SECS);
  assign sec_c = rem4 - 12'(mp4[23:18]) * 12'(MIN_SECS);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sod2 <= sod;
      hp2  <= 35'(sod) * 35'(M_HOUR);
    end
    if (adv[3]) begin
      hour3 <= hp2[33:29];
      rem3  <= rem_c[11:0];
    end
    if (adv[4]) begin
      hour4 <= hour3;
      rem4  <= rem3;
      mp4   <= 25'(rem3) * 25'(M_MIN);
    end
    if (adv[5]) begin
      tod_line[5] <= '{hour: hour4, minute: mp4[23:18], second: sec_c[SECOND_W-1:0]};
    end
    for (int k = 6; k < NSTAGE; k++) begin
      if (adv[k]) begin
        tod_line[k] <= tod_line[k-1];
      end
    end
  end

  assign tod = tod_line[NSTAGE-1];

endmodule

### src/e2c_date.sv
`timescale 1ns / 1ps
// e2c_date: stages 2 to 12, day count into year, month, day and weekday
// over 400-year gregorian eras. depends on e2c_pkg.
module e2c_date #(
  parameter int EPOCH_BITS = e2c_pkg::EPOCH_BITS_DEF
) (
  input  logic                   clk,
  input  e2c_pkg::stage_en_t     adv,
  input  logic [EPOCH_BITS-17:0] days,
  output e2c_pkg::date_t         date
);
  import e2c_pkg::*;

  localparam int DW  = EPOCH_BITS - 16;
  localparam int ZW  = ((DW > 20) ? DW : 20) + 1;
  localparam int ERW = ZW - 17;
  localparam int WW  = DW + 1;
  localparam int YW  = ERW + 9;
  localparam int SE  = ZW + 18;
  localparam int S7  = WW + 3;

  localparam int MARCH_SHIFT = 719468;
  localparam int EPOCH_WDAY  = 4;
  localparam int WEEK_DAYS   = 7;
  localparam int ERA_DAYS    = 146097;
  localparam int ERA_LAST    = 146096;
  localparam int CENT_DAYS   = 36524;
  localparam int QUAD_DAYS   = 1460;
  localparam int YEAR_DAYS   = 365;
  localparam int CENT_YEARS  = 100;
  localparam int ERA_YEARS   = 400;
  localparam int MONTH_SPAN  = 153;

  localparam logic [ZW:0] M_ERA =
    (ZW+1)'(((64'd1 << SE) + 64'(ERA_DAYS - 1)) / 64'(ERA_DAYS));
  localparam logic [WW:0] M_WEEK =
    (WW+1)'(((64'd1 << S7) + 64'(WEEK_DAYS - 1)) / 64'(WEEK_DAYS));
  localparam logic [18:0] M_QUAD =
    19'(((64'd1 << 29) + 64'(QUAD_DAYS - 1)) / 64'(QUAD_DAYS));
  localparam logic [18:0] M_CENT =
    19'(((64'd1 << 34) + 64'(CENT_DAYS - 1)) / 64'(CENT_DAYS));
  localparam logic [18:0] M_LAST =
    19'(((64'd1 << 36) + 64'(ERA_LAST - 1)) / 64'(ERA_LAST));
  localparam logic [18:0] M_YEAR =
    19'(((64'd1 << 27) + 64'(YEAR_DAYS - 1)) / 64'(YEAR_DAYS));
  localparam logic [9:0] M_CY =
    10'(((64'd1 << 16) + 64'(CENT_YEARS - 1)) / 64'(CENT_YEARS));
  localparam logic [11:0] M_MS =
    12'(((64'd1 << 19) + 64'(MONTH_SPAN - 1)) / 64'(MONTH_SPAN));

  logic [ZW-1:0]      z2, z3;
  logic [WW-1:0]      w2, w3;
  logic [2*ZW:0]      ep3;
  logic [2*WW:0]      wp3;
  logic [ERW-1:0]     era4, era5, era6, era7, era8, era9;
  logic [WEEKDAY_W-1:0] wd4, wd5, wd6, wd7, wd8, wd9, wd10, wd11;
  logic [DOE_W-1:0]   doe4, doe5, doe6, doe7, doe8, doe9;
  logic [36:0]        pq5, pc5, pl5, yp7;
  logic [DOE_W-1:0]   num6, base9;
  logic [YOE_W-1:0]   yoe8, yoe9;
  logic [18:0]        cp9;
  logic [YW-1:0]      yr10, yr11;
  logic [DOY_W-1:0]   doy10, doy11;
  logic [MP_W-1:0]    mp11;

  logic [ERW-1:0]     era_c;
  logic [ZW-1:0]      doe_c;
  logic [WW-1:0]      wd_c;
  logic [DOE_W-1:0]   doy_c;
  logic [10:0]        num_c;
  logic [22:0]        mprod_c;
  logic [MONTH_W-1:0] mo_c;
  logic [DOY_W-1:0]   day_c;
  logic [YW-1:0]      y_c;
  logic [YW+11:0]     yext_c;

  assign era_c   = ep3[2*ZW:SE];
  assign doe_c   = z3 - ZW'(era_c) * ZW'(ERA_DAYS);
  assign wd_c    = w3 - WW'(wp3[2*WW:S7]) * WW'(WEEK_DAYS);
  assign doy_c   = doe9 - (base9 - DOE_W'(cp9[18:16]));
  assign num_c   = 11'(doy10) * 11'(5) + 11'(2);
  assign mprod_c = 23'(num_c) * 23'(M_MS);
  assign mo_c    = (mp11 < MP_JAN) ? mp11 + 4'd3 : mp11 - 4'd9;
  assign day_c   = doy11 - month_start(mp11) + 9'd1;
  assign y_c     = yr11 + YW'(mo_c <= MONTH_FEB);
  assign yext_c  = (YW+12)'(y_c);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      z2 <= ZW'(days) + ZW'(MARCH_SHIFT);
      w2 <= WW'(days) + WW'(EPOCH_WDAY);
    end
    if (adv[3]) begin
      z3  <= z2;
      w3  <= w2;
      ep3 <= (2*ZW+1)'(z2) * (2*ZW+1)'(M_ERA);
      wp3 <= (2*WW+1)'(w2) * (2*WW+1)'(M_WEEK);
    end
    if (adv[4]) begin
      era4 <= era_c;
      doe4 <= doe_c[DOE_W-1:0];
      wd4  <= wd_c[WEEKDAY_W-1:0];
    end
    if (adv[5]) begin
      era5 <= era4;
      wd5  <= wd4;
      doe5 <= doe4;
      pq5  <= 37'(doe4) * 37'(M_QUAD);
      pc5  <= 37'(doe4) * 37'(M_CENT);
      pl5  <= 37'(doe4) * 37'(M_LAST);
    end
    if (adv[6]) begin
      era6 <= era5;
      wd6  <= wd5;
      doe6 <= doe5;
      num6 <= doe5 - DOE_W'(pq5[36:29]) + DOE_W'(pc5[36:34]) - DOE_W'(pl5[36]);
    end
    if (adv[7]) begin
      era7 <= era6;
      wd7  <= wd6;
      doe7 <= doe6;
      yp7  <= 37'(num6) * 37'(M_YEAR);
    end
    if (adv[8]) begin
      era8 <= era7;
      wd8  <= wd7;
      doe8 <= doe7;
      yoe8 <= yp7[35:27];
    end
    if (adv[9]) begin
      era9  <= era8;
      wd9   <= wd8;
      doe9  <= doe8;
      yoe9  <= yoe8;
      cp9   <= 19'(yoe8) * 19'(M_CY);
      base9 <= DOE_W'(yoe8) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe8[YOE_W-1:2]);
    end
    if (adv[10]) begin
      wd10  <= wd9;
      doy10 <= doy_c[DOY_W-1:0];
      yr10  <= YW'(yoe9) + YW'(era9) * YW'(ERA_YEARS);
    end
    if (adv[11]) begin
      wd11  <= wd10;
      doy11 <= doy10;
      yr11  <= yr10;
      mp11  <= mprod_c[22:19];
    end
    if (adv[12]) begin
      date <= '{year: yext_c[YEAR_W-1:0], month: mo_c, day: day_c[DAY_W-1:0],
                weekday: wd11};
    end
  end

endmodule

### src/epoch_to_calendar.sv
`timescale 1ns / 1ps
// epoch_to_calendar: top level, valid chain and handshake around the split,
// time of day and date pipelines. depends on e2c_pkg, e2c_split, e2c_tod, e2c_date.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+--------------------------------------
//   input    | valid        | stall        | epoch_seconds
//   result   | result_valid | result_stall | year month day hour minute second weekday
//
// 13 register stages, one item per cycle sustained while result_stall is low.
// depth is set by the date path: era, year-of-era, day-of-year and month steps,
// each behind its own constant-reciprocal multiplier.
// synchronous reset clears the valid bits only; no items are held across it.
// a stalled result holds stage 12; earlier stages keep moving into empty slots.
module epoch_to_calendar #(
  parameter int EPOCH_BITS = e2c_pkg::EPOCH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  output logic                            stall,
  input  logic [EPOCH_BITS-1:0]           epoch_seconds,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [e2c_pkg::YEAR_W-1:0]      year,
  output logic [e2c_pkg::MONTH_W-1:0]     month,
  output logic [e2c_pkg::DAY_W-1:0]       day,
  output logic [e2c_pkg::HOUR_W-1:0]      hour,
  output logic [e2c_pkg::MINUTE_W-1:0]    minute,
  output logic [e2c_pkg::SECOND_W-1:0]    second,
  output logic [e2c_pkg::WEEKDAY_W-1:0]   weekday
);
  import e2c_pkg::*;

  logic [NSTAGE-1:0]     vld;
  logic [NSTAGE-1:0]     vld_in;
  logic [NSTAGE:0]       rdy;
  stage_en_t             adv;
  logic [EPOCH_BITS-17:0] days;
  logic [SOD_W-1:0]      sod;
  tod_t                  tod;
  date_t                 date;

  always_comb begin
    rdy[NSTAGE] = !result_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign adv    = rdy[NSTAGE-1:0];
  assign vld_in = {vld[NSTAGE-2:0], valid};
  assign stall  = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  e2c_split #(.EPOCH_BITS(EPOCH_BITS)) u_split (
    .clk           (clk),
    .adv           (adv),
    .epoch_seconds (epoch_seconds),
    .days          (days),
    .sod           (sod)
  );

  e2c_tod u_tod (
    .clk (clk),
    .adv (adv),
    .sod (sod),
    .tod (tod)
  );

  e2c_date #(.EPOCH_BITS(EPOCH_BITS)) u_date (
    .clk  (clk),
    .adv  (adv),
    .days (days),
    .date (date)
  );

  assign result_valid = vld[NSTAGE-1];
  assign year         = date.year;
  assign month        = date.month;
  assign day          = date.day;
  assign weekday      = date.weekday;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second       = tod.second;

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> vld[0])
    else $error("accepted item did not enter the first stage");

  a_held_stage_keeps : assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE-2] && !rdy[NSTAGE-2] |=> vld[NSTAGE-2])
    else $error("held item dropped from the stage before the output");

  a_date_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && weekday <= 3'd6)
    else $error("date fields out of range");

  a_tod_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
    else $error("time of day fields out of range");

endmodule
